// ===== rtl/rfm_pkg.sv =====
// Shared package for the raycast floor texel mapper.
// Holds field widths, function and direction codes, register indexes,
// the sequencer state type and the control groups of the datapath units.
package rfm_pkg;

   localparam int ROWS_W     = 11;
   localparam int CAM_W      = 22;
   localparam int TEX_SIZE_W = 11;
   localparam int COORD_W    = 10;
   localparam int ROW_W      = 11;
   localparam int COL_W      = 10;
   localparam int MAPC_W     = 6;
   localparam int FRAC_IN_W  = 16;
   localparam int DIST_IN_W  = 24;
   localparam int DIR_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;

   localparam logic FUNC_SETUP = 1'b0;
   localparam logic FUNC_ROW   = 1'b1;

   localparam logic SIDE_X = 1'b0;
   localparam logic SIDE_Y = 1'b1;

   localparam logic [DIR_W-1:0] DIR_ZERO = 2'd0;
   localparam logic [DIR_W-1:0] DIR_POS  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_NEG  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_RSVD = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_ROWS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_X       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_Y       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT  = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIST,
      ST_WLOAD,
      ST_WEIGHT,
      ST_MLOAD,
      ST_MUL,
      ST_FLOAD,
      ST_FRAC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

   typedef struct packed {
      logic load_mul;
      logic step_mul;
      logic load_frac;
      logic step_frac;
   } lerp_ctl_type;

endpackage

// ===== rtl/rfm_div.sv =====
// Radix-2 restoring divider, one quotient bit per step.
// Depends on rfm_pkg for its control group; the sequencer counts the steps.
module rfm_div #(
   parameter int DEN_W   = 24,
   parameter int SHIFT_W = 27
) (
   input  logic                  clock,
   input  rfm_pkg::div_ctl_type  ctl,
   input  logic [DEN_W:0]        rem_init,
   input  logic [SHIFT_W-1:0]    shin_init,
   input  logic [DEN_W-1:0]      den,
   output logic [SHIFT_W-1:0]    quot
);

   localparam int REM_W = DEN_W + 1;

   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [SHIFT_W-1:0] shin_ff, shin_in;
   logic [SHIFT_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [REM_W-1:0]   trial;
   logic               fits;

   // The partial remainder stays below the divisor, so one more bit fits.
   assign trial = {rem_ff[REM_W-2:0], shin_ff[SHIFT_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      shin_in = shin_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      if (ctl.load) begin
         rem_in  = rem_init;
         shin_in = shin_init;
         quot_in = '0;
         den_in  = den;
      end else if (ctl.step) begin
         rem_in  = fits ? (trial - {1'b0, den_ff}) : trial;
         shin_in = {shin_ff[SHIFT_W-2:0], 1'b0};
         quot_in = {quot_ff[SHIFT_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      shin_ff <= shin_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign quot = quot_ff;

endmodule

// ===== rtl/rfm_lerp.sv =====
// One texture axis: bit-serial lerp product and bit-serial scale by texture size.
// Depends on rfm_pkg for widths and the control group; the sequencer counts the steps.
module rfm_lerp #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  rfm_pkg::lerp_ctl_type           ctl,
   input  logic [FRAC_BITS+1:0]            weight,
   input  logic [rfm_pkg::CAM_W-1:0]       cam,
   input  logic [FRAC_BITS+6:0]            point,
   input  logic [rfm_pkg::TEX_SIZE_W-1:0]  size,
   output logic [rfm_pkg::COORD_W-1:0]     coord
);

   localparam int F    = FRAC_BITS;
   localparam int UP   = (F >= 16) ? F - 16 : 0;
   localparam int DN   = (F >= 16) ? 0 : 16 - F;
   localparam int CQ_W = rfm_pkg::CAM_W + UP;
   localparam int P_W  = 2 * F;
   localparam int Q_W  = F + rfm_pkg::TEX_SIZE_W;
   localparam int W_W  = F + 2;
   localparam int S_W  = rfm_pkg::TEX_SIZE_W;

   logic [CQ_W-1:0] cam_up, cam_f;
   logic [P_W-1:0]  diff;

   logic [P_W-1:0] diff_ff, diff_in;
   logic [W_W-1:0] wsh_ff, wsh_in;
   logic [P_W-1:0] acc_ff, acc_in;
   logic [F-1:0]   cfrac_ff, cfrac_in;
   logic [F-1:0]   frac_ff, frac_in;
   logic [S_W-1:0] ssh_ff, ssh_in;
   logic [Q_W-1:0] prod_ff, prod_in;

   // Only the low 2F bits of weight * (point - cam) reach the fraction of the
   // lerped point, so the difference is kept modulo 2^(2F).
   assign cam_up = CQ_W'(cam) << UP;
   assign cam_f  = cam_up >> DN;
   assign diff   = P_W'(point) - P_W'(cam_f);

   always_comb begin
      diff_in  = diff_ff;
      wsh_in   = wsh_ff;
      acc_in   = acc_ff;
      cfrac_in = cfrac_ff;
      frac_in  = frac_ff;
      ssh_in   = ssh_ff;
      prod_in  = prod_ff;
      if (ctl.load_mul) begin
         diff_in  = diff;
         wsh_in   = weight;
         acc_in   = '0;
         cfrac_in = F'(cam_f);
      end else if (ctl.step_mul) begin
         acc_in = {acc_ff[P_W-2:0], 1'b0} + (wsh_ff[W_W-1] ? diff_ff : '0);
         wsh_in = {wsh_ff[W_W-2:0], 1'b0};
      end
      // The texel index modulo size is the fraction of the point times size.
      if (ctl.load_frac) begin
         frac_in = cfrac_ff + acc_ff[P_W-1:F];
         ssh_in  = size;
         prod_in = '0;
      end else if (ctl.step_frac) begin
         prod_in = {prod_ff[Q_W-2:0], 1'b0} + (ssh_ff[S_W-1] ? Q_W'(frac_ff) : '0);
         ssh_in  = {ssh_ff[S_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      wsh_ff   <= wsh_in;
      acc_ff   <= acc_in;
      cfrac_ff <= cfrac_in;
      frac_ff  <= frac_in;
      ssh_ff   <= ssh_in;
      prod_ff  <= prod_in;
   end

   assign coord = prod_ff[F+rfm_pkg::COORD_W-1:F];

endmodule

// ===== rtl/raycast_floor_texel_mapper_unit.sv =====
// Top level of the raycast floor texel mapper: floor and ceiling casting for one column.
// Depends on rfm_pkg, rfm_div (shared serial divider) and rfm_lerp (one per texture axis).
//
//  channel | direction | handshake           | word
//  req_    | in        | req_valid/req_ready | setup or row-step command with wall hit
//  rsp_    | out       | rsp_valid/rsp_ready | column, floor row, sky row, texel x/y, last
//  csr_    | in        | csr_we              | register index and write data, no wait
//
// A setup word, a row word while no column is loaded, and a row word past the screen
// bottom leave the unit idle. A row word that produces a result runs the single
// radix-2 divider (row distance, then weight) and the bit-serial lerp and size scaling
// before the next word is accepted. Rows at or above the horizon, or with a zero wall
// distance, skip the divider. Reset is synchronous and restores the control, the
// configuration and the column registers, but not the result or datapath registers.
// A result waits in the output register while the next word is accepted; the unit only
// stalls at the end of a computation if the previous result has not been taken.
module raycast_floor_texel_mapper_unit #(
   parameter int MAP_SIZE  = 64,
   parameter int FRAC_BITS = 16,
   parameter int MAX_ROWS  = 1024
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [rfm_pkg::COL_W-1:0]         req_column,
   input  logic [rfm_pkg::COL_W-1:0]         req_start_row,
   input  logic                              req_side,
   input  logic [rfm_pkg::DIR_W-1:0]         req_dir_x_sign,
   input  logic [rfm_pkg::DIR_W-1:0]         req_dir_y_sign,
   input  logic [rfm_pkg::MAPC_W-1:0]        req_map_x,
   input  logic [rfm_pkg::MAPC_W-1:0]        req_map_y,
   input  logic [rfm_pkg::FRAC_IN_W-1:0]     req_wall_frac,
   input  logic [rfm_pkg::DIST_IN_W-1:0]     req_wall_dist,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rfm_pkg::COL_W-1:0]         rsp_out_column,
   output logic [rfm_pkg::COORD_W-1:0]       rsp_floor_row,
   output logic [rfm_pkg::ROWS_W-1:0]        rsp_sky_row,
   output logic [rfm_pkg::COORD_W-1:0]       rsp_tex_x,
   output logic [rfm_pkg::COORD_W-1:0]       rsp_tex_y,
   output logic                              rsp_last,

   input  logic                              csr_we,
   input  logic [rfm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rfm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int F       = FRAC_BITS;
   localparam int UP      = (F >= 16) ? F - 16 : 0;
   localparam int DN      = (F >= 16) ? 0 : 16 - F;
   localparam int PT_W    = F + 7;                        // floor point, Q7.F
   localparam int FQ_W    = (F >= 16) ? F : 16;
   localparam int HF_W    = (F >= 16) ? F + 8 : 24;       // wall distance, internal format
   localparam int DHW     = rfm_pkg::DIST_IN_W + UP;
   localparam int REM_W   = HF_W + 1;
   localparam int SH_W    = rfm_pkg::ROWS_W + F;          // row distance bits
   localparam int W_W     = F + 2;                        // weight, just under 4.0
   localparam int DIST_STEPS = SH_W;
   localparam int W_STEPS    = W_W;
   localparam int SIZE_STEPS = rfm_pkg::TEX_SIZE_W;
   localparam int CNT_W   = $clog2(SH_W);
   localparam int MAP_N   = 2 ** rfm_pkg::MAPC_W;

   // Configuration registers.
   logic [rfm_pkg::ROWS_W-1:0]     screen_rows_ff;
   logic [rfm_pkg::CAM_W-1:0]      cam_x_ff, cam_y_ff;
   logic [rfm_pkg::TEX_SIZE_W-1:0] tex_width_ff, tex_height_ff;

   // Column state.
   logic [PT_W-1:0]                floor_px_ff, floor_py_ff;
   logic [rfm_pkg::DIST_IN_W-1:0]  hit_dist_ff;
   logic [rfm_pkg::COL_W-1:0]      cur_column_ff;
   logic [rfm_pkg::ROW_W-1:0]      cur_row_ff;
   logic                           active_ff;

   // Sequencer.
   rfm_pkg::state_type             state_ff, state_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           sat_ff, sat_in;
   logic                           rsp_load;

   // Output register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rfm_pkg::COL_W-1:0]      rsp_out_column_ff;
   logic [rfm_pkg::COORD_W-1:0]    rsp_floor_row_ff;
   logic [rfm_pkg::ROWS_W-1:0]     rsp_sky_row_ff;
   logic [rfm_pkg::COORD_W-1:0]    rsp_tex_x_ff, rsp_tex_y_ff;
   logic                           rsp_last_ff;

   rfm_pkg::div_ctl_type           div_ctl;
   rfm_pkg::lerp_ctl_type          lerp_ctl;
   logic [REM_W-1:0]               div_rem_init, w_rem0;
   logic [SH_W-1:0]                div_shin_init, div_quot;
   logic [HF_W-1:0]                div_den;
   logic [W_W-1:0]                 weight;
   logic [rfm_pkg::COORD_W-1:0]    tex_x, tex_y;

   logic                           accept, setup_go, row_go;
   logic [rfm_pkg::ROWS_W-1:0]     h;
   logic [rfm_pkg::ROWS_W:0]       y, y2, h_ext;
   logic                           row_ok, d_pos;
   logic [rfm_pkg::ROWS_W:0]       d_val;
   logic [DHW-1:0]                 hd_up;
   logic [HF_W-1:0]                hf;
   logic [FQ_W-1:0]                frac_up;
   logic [F-1:0]                   frac_f;
   logic [rfm_pkg::MAPC_W-1:0]     map_mod [MAP_N];
   logic [PT_W-1:0]                mx, my, fr, one;
   logic [PT_W-1:0]                px_new, py_new;
   logic [rfm_pkg::ROWS_W-1:0]     cur_row_h;
   logic                           cur_last;

   // Map cell modulo the map size, as a constant table over the cell field.
   for (genvar i = 0; i < MAP_N; i++) begin : g_map_mod
      assign map_mod[i] = rfm_pkg::MAPC_W'(i % MAP_SIZE);
   end

   // Screen height clamped to the row limit.
   assign h = (int'(screen_rows_ff) > MAX_ROWS) ? rfm_pkg::ROWS_W'(MAX_ROWS) : screen_rows_ff;
   assign h_ext = {1'b0, h};

   assign y      = {1'b0, cur_row_ff} + 12'd1;
   assign y2     = {y[rfm_pkg::ROWS_W-1:0], 1'b0};
   assign row_ok = y < h_ext;
   assign d_pos  = y2 > h_ext;
   assign d_val  = y2 - h_ext;

   assign hd_up = DHW'(hit_dist_ff) << UP;
   assign hf    = HF_W'(hd_up >> DN);

   assign req_ready = (state_ff == rfm_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign setup_go  = accept && (req_func == rfm_pkg::FUNC_SETUP);
   assign row_go    = accept && (req_func == rfm_pkg::FUNC_ROW) && active_ff && row_ok;

   // Floor point at the base of the hit wall.
   assign frac_up = FQ_W'(req_wall_frac) << UP;
   assign frac_f  = F'(frac_up >> DN);
   assign mx  = PT_W'({map_mod[req_map_x], {F{1'b0}}});
   assign my  = PT_W'({map_mod[req_map_y], {F{1'b0}}});
   assign fr  = PT_W'(frac_f);
   assign one = PT_W'(1) << F;

   always_comb begin
      if (req_side == rfm_pkg::SIDE_X && req_dir_x_sign == rfm_pkg::DIR_POS) begin
         px_new = mx;
         py_new = my + fr;
      end else if (req_side == rfm_pkg::SIDE_X && req_dir_x_sign == rfm_pkg::DIR_NEG) begin
         px_new = mx + one;
         py_new = my + fr;
      end else if (req_side == rfm_pkg::SIDE_Y && req_dir_y_sign == rfm_pkg::DIR_POS) begin
         px_new = mx + fr;
         py_new = my;
      end else begin
         // Covers the y side going negative or with no y direction, and an x side hit with no x direction.
         px_new = mx + fr;
         py_new = my + one;
      end
   end

   // The divider first forms the row distance H<<F / d. For the weight it starts from
   // the upper part of distance<<F: if that already reaches the wall distance the
   // quotient would not fit and the weight saturates, otherwise F+2 bits remain.
   assign w_rem0 = REM_W'(div_quot >> 2);

   always_comb begin
      if (state_ff == rfm_pkg::ST_WLOAD) begin
         div_rem_init  = w_rem0;
         div_shin_init = {div_quot[1:0], {(SH_W-2){1'b0}}};
         div_den       = hf;
      end else begin
         div_rem_init  = '0;
         div_shin_init = {h, {F{1'b0}}};
         div_den       = HF_W'(d_val);
      end
   end

   assign weight = sat_ff ? {W_W{1'b1}} : div_quot[W_W-1:0];

   // Sequencer: next state and unit controls.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sat_in   = sat_ff;
      div_ctl  = '0;
      lerp_ctl = '0;
      rsp_load = 1'b0;
      unique case (state_ff)
         rfm_pkg::ST_IDLE: begin
            if (row_go) begin
               if (d_pos && (hf != '0)) begin
                  div_ctl.load = 1'b1;
                  cnt_in       = CNT_W'(DIST_STEPS - 1);
                  sat_in       = 1'b0;
                  state_in     = rfm_pkg::ST_DIST;
               end else begin
                  sat_in   = 1'b1;
                  state_in = rfm_pkg::ST_MLOAD;
               end
            end
         end
         rfm_pkg::ST_DIST: begin
            div_ctl.step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = rfm_pkg::ST_WLOAD;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         rfm_pkg::ST_WLOAD: begin
            if (w_rem0 >= {1'b0, hf}) begin
               sat_in   = 1'b1;
               state_in = rfm_pkg::ST_MLOAD;
            end else begin
               div_ctl.load = 1'b1;
               cnt_in       = CNT_W'(W_STEPS - 1);
               state_in     = rfm_pkg::ST_WEIGHT;
            end
         end
         rfm_pkg::ST_WEIGHT: begin
            div_ctl.step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = rfm_pkg::ST_MLOAD;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         rfm_pkg::ST_MLOAD: begin
            lerp_ctl.load_mul = 1'b1;
            cnt_in            = CNT_W'(W_STEPS - 1);
            state_in          = rfm_pkg::ST_MUL;
         end
         rfm_pkg::ST_MUL: begin
            lerp_ctl.step_mul = 1'b1;
            if (cnt_ff == '0) begin
               state_in = rfm_pkg::ST_FLOAD;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         rfm_pkg::ST_FLOAD: begin
            lerp_ctl.load_frac = 1'b1;
            cnt_in             = CNT_W'(SIZE_STEPS - 1);
            state_in           = rfm_pkg::ST_FRAC;
         end
         rfm_pkg::ST_FRAC: begin
            lerp_ctl.step_frac = 1'b1;
            if (cnt_ff == '0) begin
               state_in = rfm_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         rfm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = rfm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rfm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfm_pkg::ST_IDLE;
         cnt_ff   <= '0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sat_ff   <= sat_in;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_rows_ff <= 11'd480;
         cam_x_ff       <= '0;
         cam_y_ff       <= '0;
         tex_width_ff   <= 11'd64;
         tex_height_ff  <= 11'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            rfm_pkg::CSR_SCREEN_ROWS: screen_rows_ff <= csr_wdata[rfm_pkg::ROWS_W-1:0];
            rfm_pkg::CSR_CAM_X:       cam_x_ff       <= csr_wdata;
            rfm_pkg::CSR_CAM_Y:       cam_y_ff       <= csr_wdata;
            rfm_pkg::CSR_TEX_WIDTH:   tex_width_ff   <= csr_wdata[rfm_pkg::TEX_SIZE_W-1:0];
            rfm_pkg::CSR_TEX_HEIGHT:  tex_height_ff  <= csr_wdata[rfm_pkg::TEX_SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Column state: a setup loads the hit, a row word moves one row down.
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_px_ff   <= '0;
         floor_py_ff   <= '0;
         hit_dist_ff   <= 24'd1;
         cur_column_ff <= '0;
         cur_row_ff    <= '0;
         active_ff     <= 1'b0;
      end else if (setup_go) begin
         floor_px_ff   <= px_new;
         floor_py_ff   <= py_new;
         hit_dist_ff   <= req_wall_dist;
         cur_column_ff <= req_column;
         cur_row_ff    <= {1'b0, req_start_row};
         active_ff     <= ({1'b0, req_start_row} + 11'd1) < h;
      end else if (accept && (req_func == rfm_pkg::FUNC_ROW) && active_ff) begin
         if (!row_ok) begin
            active_ff <= 1'b0;
         end else begin
            cur_row_ff <= y[rfm_pkg::ROW_W-1:0];
            // The final row closes the column as soon as it is taken in.
            if ((y + 12'd1) >= h_ext) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   rfm_div #(
      .DEN_W   (HF_W),
      .SHIFT_W (SH_W)
   ) u_div (
      .clock     (clock),
      .ctl       (div_ctl),
      .rem_init  (div_rem_init),
      .shin_init (div_shin_init),
      .den       (div_den),
      .quot      (div_quot)
   );

   rfm_lerp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lerp_x (
      .clock  (clock),
      .ctl    (lerp_ctl),
      .weight (weight),
      .cam    (cam_x_ff),
      .point  (floor_px_ff),
      .size   (tex_width_ff),
      .coord  (tex_x)
   );

   rfm_lerp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lerp_y (
      .clock  (clock),
      .ctl    (lerp_ctl),
      .weight (weight),
      .cam    (cam_y_ff),
      .point  (floor_py_ff),
      .size   (tex_height_ff),
      .coord  (tex_y)
   );

   // By the time the result is loaded cur_row already holds this row.
   assign cur_row_h = cur_row_ff;
   assign cur_last  = ({1'b0, cur_row_h} + 12'd1) >= h_ext;

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_out_column_ff <= cur_column_ff;
         rsp_floor_row_ff  <= cur_row_h[rfm_pkg::COORD_W-1:0];
         rsp_sky_row_ff    <= h - cur_row_h;
         rsp_tex_x_ff      <= tex_x;
         rsp_tex_y_ff      <= tex_y;
         rsp_last_ff       <= cur_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_column = rsp_out_column_ff;
   assign rsp_floor_row  = rsp_floor_row_ff;
   assign rsp_sky_row    = rsp_sky_row_ff;
   assign rsp_tex_x      = rsp_tex_x_ff;
   assign rsp_tex_y      = rsp_tex_y_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // A finished computation moves into a free output slot and frees the input.
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfm_pkg::ST_DONE && (!rsp_valid_ff || rsp_ready))
      |=> (rsp_valid_ff && state_ff == rfm_pkg::ST_IDLE))
      else $error("finished result not loaded into the output register");

   // The weight division only runs when its quotient is known to fit.
   a_weight_not_sat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfm_pkg::ST_WEIGHT) |-> !sat_ff)
      else $error("weight division running on a saturated weight");

   // The lerp multiply is always entered through its load cycle.
   a_mul_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfm_pkg::ST_MUL && $past(state_ff) != rfm_pkg::ST_MUL)
      |-> ($past(state_ff) == rfm_pkg::ST_MLOAD))
      else $error("lerp multiply started without loading its operands");

   // A result row is only started for a loaded column below the last row.
   a_row_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfm_pkg::ST_IDLE && state_in != rfm_pkg::ST_IDLE)
      |-> (active_ff && row_ok))
      else $error("row computation started without an active column");
`endif

endmodule

// ===== tb/rfm_texel_checker.sv =====
// Checker for the raycast floor texel mapper: watches the request, result and register ports,
// predicts every result word and compares it with what the unit returns.
// Depends on rfm_pkg for field widths, function, side, direction and register codes.
module rfm_texel_checker #(
   parameter int MAP_SIZE  = 64,
   parameter int FRAC_BITS = 16,
   parameter int MAX_ROWS  = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_func,
   input  logic [rfm_pkg::COL_W-1:0]         req_column,
   input  logic [rfm_pkg::COL_W-1:0]         req_start_row,
   input  logic                              req_side,
   input  logic [rfm_pkg::DIR_W-1:0]         req_dir_x_sign,
   input  logic [rfm_pkg::DIR_W-1:0]         req_dir_y_sign,
   input  logic [rfm_pkg::MAPC_W-1:0]        req_map_x,
   input  logic [rfm_pkg::MAPC_W-1:0]        req_map_y,
   input  logic [rfm_pkg::FRAC_IN_W-1:0]     req_wall_frac,
   input  logic [rfm_pkg::DIST_IN_W-1:0]     req_wall_dist,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [rfm_pkg::COL_W-1:0]         rsp_out_column,
   input  logic [rfm_pkg::COORD_W-1:0]       rsp_floor_row,
   input  logic [rfm_pkg::ROWS_W-1:0]        rsp_sky_row,
   input  logic [rfm_pkg::COORD_W-1:0]       rsp_tex_x,
   input  logic [rfm_pkg::COORD_W-1:0]       rsp_tex_y,
   input  logic                              rsp_last,
   input  logic                              csr_we,
   input  logic [rfm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rfm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                mismatch_count,
   output int                                texels_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint UNIT       = longint'(1) << FRAC_BITS;
   localparam longint WEIGHT_MAX = (longint'(1) << (FRAC_BITS + 2)) - 1;
   localparam int     PT_W       = FRAC_BITS + 7;

   typedef struct packed {
      logic [rfm_pkg::COL_W-1:0]   column;
      logic [rfm_pkg::COORD_W-1:0] floor_row;
      logic [rfm_pkg::ROWS_W-1:0]  sky_row;
      logic [rfm_pkg::COORD_W-1:0] tex_x;
      logic [rfm_pkg::COORD_W-1:0] tex_y;
      logic                        last;
   } floor_texel_type;

   logic [rfm_pkg::ROWS_W-1:0]      rows_cfg;
   logic [rfm_pkg::CAM_W-1:0]       cam_x_cfg;
   logic [rfm_pkg::CAM_W-1:0]       cam_y_cfg;
   logic [rfm_pkg::TEX_SIZE_W-1:0]  tex_w_cfg;
   logic [rfm_pkg::TEX_SIZE_W-1:0]  tex_h_cfg;

   logic [PT_W-1:0]                 floor_x;
   logic [PT_W-1:0]                 floor_y;
   logic [rfm_pkg::DIST_IN_W-1:0]   hit_dist;
   logic [rfm_pkg::COL_W-1:0]       column_q;
   logic [rfm_pkg::COL_W-1:0]       row_q;
   logic                            column_live;

   floor_texel_type                 texel_queue[$];

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [10:0] got,
                                input logic [10:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0d, %0d predicted", name, got, want));
   endtask

   // Inputs with 16 fraction bits move to the internal format, truncating.
   function automatic longint from_q16(input longint v);
      if (FRAC_BITS >= 16)
         return v << (FRAC_BITS - 16);
      return v >> (16 - FRAC_BITS);
   endfunction

   function automatic longint floor_mod(input longint v, input longint m);
      longint r;
      if (m == 0)
         return 0;
      r = v % m;
      if (r < 0)
         r += m;
      return r;
   endfunction

   // Lerp from camera to floor point, then scale by texture size; both shifts floor.
   function automatic logic [rfm_pkg::COORD_W-1:0] texel_coord(input longint cam,
                                                               input longint pt,
                                                               input longint wgt,
                                                               input longint size);
      longint c;
      longint p;
      c = from_q16(cam);
      p = c + ((wgt * (pt - c)) >>> FRAC_BITS);
      return rfm_pkg::COORD_W'(floor_mod((p * size) >>> FRAC_BITS, size));
   endfunction

   // Applies one accepted request word to the predicted state; returns 1 when it yields a texel.
   function automatic bit cast_step(output floor_texel_type texel);
      longint h;
      longint y;
      longint d;
      longint hf;
      longint wgt;
      longint dist_row;
      longint mx;
      longint my;
      longint fr;
      texel = '0;
      h = (rows_cfg > MAX_ROWS) ? longint'(MAX_ROWS) : longint'(rows_cfg);
      if (req_func == rfm_pkg::FUNC_SETUP) begin
         mx = longint'(req_map_x % MAP_SIZE) << FRAC_BITS;
         my = longint'(req_map_y % MAP_SIZE) << FRAC_BITS;
         fr = from_q16(longint'(req_wall_frac));
         if (req_side == rfm_pkg::SIDE_X && req_dir_x_sign == rfm_pkg::DIR_POS) begin
            floor_x = PT_W'(mx);
            floor_y = PT_W'(my + fr);
         end else if (req_side == rfm_pkg::SIDE_X && req_dir_x_sign == rfm_pkg::DIR_NEG) begin
            floor_x = PT_W'(mx + UNIT);
            floor_y = PT_W'(my + fr);
         end else if (req_side == rfm_pkg::SIDE_Y && req_dir_y_sign == rfm_pkg::DIR_POS) begin
            floor_x = PT_W'(mx + fr);
            floor_y = PT_W'(my);
         end else begin
            // Also covers an x side hit whose x direction is zero.
            floor_x = PT_W'(mx + fr);
            floor_y = PT_W'(my + UNIT);
         end
         hit_dist = req_wall_dist;
         column_q = req_column;
         row_q = req_start_row;
         column_live = (longint'(req_start_row) + 1) < h;
         return 1'b0;
      end
      if (!column_live)
         return 1'b0;
      y = longint'(row_q) + 1;
      if (y >= h) begin
         column_live = 1'b0;
         return 1'b0;
      end
      d = 2 * y - h;
      hf = from_q16(longint'(hit_dist));
      if (d <= 0 || hf == 0) begin
         wgt = WEIGHT_MAX;
      end else begin
         dist_row = (h << FRAC_BITS) / d;
         wgt = (dist_row << FRAC_BITS) / hf;
         if (wgt > WEIGHT_MAX)
            wgt = WEIGHT_MAX;
      end
      texel.column = column_q;
      texel.floor_row = rfm_pkg::COORD_W'(y);
      texel.sky_row = rfm_pkg::ROWS_W'(h - y);
      texel.tex_x = texel_coord(longint'(cam_x_cfg), longint'(floor_x), wgt,
                                longint'(tex_w_cfg));
      texel.tex_y = texel_coord(longint'(cam_y_cfg), longint'(floor_y), wgt,
                                longint'(tex_h_cfg));
      texel.last = (y + 1 >= h);
      row_q = rfm_pkg::COL_W'(y);
      if (texel.last)
         column_live = 1'b0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      floor_texel_type want;
      floor_texel_type predicted;
      if (reset) begin
         rows_cfg = 11'd480;
         cam_x_cfg = '0;
         cam_y_cfg = '0;
         tex_w_cfg = 11'd64;
         tex_h_cfg = 11'd64;
         floor_x = '0;
         floor_y = '0;
         hit_dist = rfm_pkg::DIST_IN_W'(1);
         column_q = '0;
         row_q = '0;
         column_live = 1'b0;
         texel_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               rfm_pkg::CSR_SCREEN_ROWS: rows_cfg = rfm_pkg::ROWS_W'(csr_wdata);
               rfm_pkg::CSR_CAM_X:       cam_x_cfg = rfm_pkg::CAM_W'(csr_wdata);
               rfm_pkg::CSR_CAM_Y:       cam_y_cfg = rfm_pkg::CAM_W'(csr_wdata);
               rfm_pkg::CSR_TEX_WIDTH:   tex_w_cfg = rfm_pkg::TEX_SIZE_W'(csr_wdata);
               rfm_pkg::CSR_TEX_HEIGHT:  tex_h_cfg = rfm_pkg::TEX_SIZE_W'(csr_wdata);
               default: ;
            endcase
         end
         // A result word leaving now always belongs to an earlier request, so check first.
         if (rsp_valid && rsp_ready) begin
            if (texel_queue.size() == 0) begin
               report_mismatch($sformatf("result word for row %0d with none predicted",
                                         rsp_floor_row));
            end else begin
               want = texel_queue.pop_front();
               compare_field("out_column", 11'(rsp_out_column), 11'(want.column));
               compare_field("floor_row", 11'(rsp_floor_row), 11'(want.floor_row));
               compare_field("sky_row", rsp_sky_row, want.sky_row);
               compare_field("tex_x", 11'(rsp_tex_x), 11'(want.tex_x));
               compare_field("tex_y", 11'(rsp_tex_y), 11'(want.tex_y));
               compare_field("last", 11'(rsp_last), 11'(want.last));
            end
         end
         if (req_valid && req_ready) begin
            if (cast_step(predicted))
               texel_queue.push_back(predicted);
         end
      end
      texels_pending <= texel_queue.size();
   end

endmodule

// ===== tb/tb.sv =====
// Top of the floor texel mapper testbench: clock, reset, register setup and request stimulus,
// a randomly stalling result receiver and the final verdict.
// Depends on rfm_pkg, the unit raycast_floor_texel_mapper_unit and rfm_texel_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One request word as the sender sees it; every field maps onto one req_ port.
   typedef struct packed {
      logic                           func;
      logic [rfm_pkg::COL_W-1:0]      column;
      logic [rfm_pkg::COL_W-1:0]      start_row;
      logic                           side;
      logic [rfm_pkg::DIR_W-1:0]      dx;
      logic [rfm_pkg::DIR_W-1:0]      dy;
      logic [rfm_pkg::MAPC_W-1:0]     map_x;
      logic [rfm_pkg::MAPC_W-1:0]     map_y;
      logic [rfm_pkg::FRAC_IN_W-1:0]  frac;
      logic [rfm_pkg::DIST_IN_W-1:0]  wall_dist;
   } cast_word_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic                              req_func;
   logic [rfm_pkg::COL_W-1:0]         req_column;
   logic [rfm_pkg::COL_W-1:0]         req_start_row;
   logic                              req_side;
   logic [rfm_pkg::DIR_W-1:0]         req_dir_x_sign;
   logic [rfm_pkg::DIR_W-1:0]         req_dir_y_sign;
   logic [rfm_pkg::MAPC_W-1:0]        req_map_x;
   logic [rfm_pkg::MAPC_W-1:0]        req_map_y;
   logic [rfm_pkg::FRAC_IN_W-1:0]     req_wall_frac;
   logic [rfm_pkg::DIST_IN_W-1:0]     req_wall_dist;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [rfm_pkg::COL_W-1:0]         rsp_out_column;
   logic [rfm_pkg::COORD_W-1:0]       rsp_floor_row;
   logic [rfm_pkg::ROWS_W-1:0]        rsp_sky_row;
   logic [rfm_pkg::COORD_W-1:0]       rsp_tex_x;
   logic [rfm_pkg::COORD_W-1:0]       rsp_tex_y;
   logic                              rsp_last;
   logic                              csr_we;
   logic [rfm_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [rfm_pkg::CSR_DATA_W-1:0]    csr_wdata;

   int                                mismatch_count;
   int                                texels_pending;

   // Shared between the sender and the receiver process.
   bit                                steady_flow;      // no idle gaps on either side while set
   int                                rsp_hold_cycles;  // one long receiver hold-off, in cycles

   // Register values as last written, so that one register can change on its own.
   int                                cur_rows;
   int                                cur_cam_x;
   int                                cur_cam_y;
   int                                cur_tex_w;
   int                                cur_tex_h;
   int                                words_sent;

   raycast_floor_texel_mapper_unit u_dut (.*);

   rfm_texel_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Safety net: the slowest correct run stays far below this.
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   // Idle gaps are mostly absent or short, with a rare long one.
   function automatic int gap_len();
      int r;
      if (steady_flow)
         return 0;
      r = $urandom_range(99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(3, 1);
      if (r < 97)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Receiver: ready is low for random gaps, and for one long hold-off when the sender
   // asks for it. The hold-off lets the unit fill its output register and stall its input.
   initial begin
      int low_left;
      low_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            low_left = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (low_left > 0) begin
            rsp_ready <= 1'b0;
            low_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(7) == 0)
               low_left = gap_len();
         end
      end
   end

   // A row word reads only its function bit, so the other fields are left random.
   function automatic cast_word_type row_word();
      cast_word_type w;
      w.func = rfm_pkg::FUNC_ROW;
      w.column = rfm_pkg::COL_W'($urandom_range(1023));
      w.start_row = rfm_pkg::COL_W'($urandom_range(1023));
      w.side = 1'($urandom_range(1));
      w.dx = rfm_pkg::DIR_W'($urandom_range(3));
      w.dy = rfm_pkg::DIR_W'($urandom_range(3));
      w.map_x = rfm_pkg::MAPC_W'($urandom_range(63));
      w.map_y = rfm_pkg::MAPC_W'($urandom_range(63));
      w.frac = rfm_pkg::FRAC_IN_W'($urandom_range(16'hFFFF));
      w.wall_dist = rfm_pkg::DIST_IN_W'($urandom_range(24'hFFFFFF));
      return w;
   endfunction

   function automatic cast_word_type setup_at(input int start, input logic side,
                                              input logic [rfm_pkg::DIR_W-1:0] dx,
                                              input logic [rfm_pkg::DIR_W-1:0] dy,
                                              input logic [rfm_pkg::DIST_IN_W-1:0] wall_dist);
      cast_word_type w;
      w = row_word();
      w.func = rfm_pkg::FUNC_SETUP;
      w.start_row = rfm_pkg::COL_W'(start);
      w.side = side;
      w.dx = dx;
      w.dy = dy;
      w.wall_dist = wall_dist;
      return w;
   endfunction

   // Wall distances: mostly a few map units, some anywhere in range, and the extremes.
   function automatic logic [rfm_pkg::DIST_IN_W-1:0] pick_dist();
      int r;
      r = $urandom_range(99);
      if (r < 4)
         return '0;
      if (r < 8)
         return '1;
      if (r < 50)
         return rfm_pkg::DIST_IN_W'($urandom_range(24'hFFFFFF));
      return rfm_pkg::DIST_IN_W'($urandom_range(24'h100000, 24'h8000));
   endfunction

   function automatic int pick_rows();
      case ($urandom_range(7))
         0: return 2;
         1: return 1024;
         2: return 2047;
         3: return 480;
         4: return $urandom_range(2047, 2);
         default: return $urandom_range(1024, 2);
      endcase
   endfunction

   function automatic int pick_cam();
      case ($urandom_range(3))
         0: return 0;
         1: return 22'h3FFFFF;
         default: return $urandom_range(22'h3FFFFF);
      endcase
   endfunction

   function automatic int pick_tex();
      case ($urandom_range(8))
         0: return 0;
         1: return 1;
         2: return 1024;
         3: return 2047;
         4: return 64;
         5: return $urandom_range(2047);
         default: return $urandom_range(1024, 1);
      endcase
   endfunction

   // Offers one word, holds it until the unit takes it, then maybe idles.
   // With no gap, valid simply stays high for the next word.
   task automatic send_word(input cast_word_type w);
      int gap;
      req_valid <= 1'b1;
      req_func <= w.func;
      req_column <= w.column;
      req_start_row <= w.start_row;
      req_side <= w.side;
      req_dir_x_sign <= w.dx;
      req_dir_y_sign <= w.dy;
      req_map_x <= w.map_x;
      req_map_y <= w.map_y;
      req_wall_frac <= w.frac;
      req_wall_dist <= w.wall_dist;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      words_sent++;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // A setup word with random wall hit data followed by a number of row words.
   task automatic send_column(input int start, input int rows);
      send_word(setup_at(start, 1'($urandom_range(1)), rfm_pkg::DIR_W'($urandom_range(3)),
                         rfm_pkg::DIR_W'($urandom_range(3)), pick_dist()));
      repeat (rows) send_word(row_word());
   endtask

   // Stops offering words and waits until every predicted texel has come back. A row word
   // that yields nothing leaves the unit idle, so the margin after that covers a full row.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (texels_pending != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rfm_pkg::CSR_IDX_W-1:0] idx, input int data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= rfm_pkg::CSR_DATA_W'(data);
      @(posedge clock);
   endtask

   // Registers are only written while the unit has nothing in flight.
   task automatic write_regs(input int rows, input int cx, input int cy,
                             input int tw, input int th);
      drain();
      write_reg(rfm_pkg::CSR_SCREEN_ROWS, rows);
      write_reg(rfm_pkg::CSR_CAM_X, cx);
      write_reg(rfm_pkg::CSR_CAM_Y, cy);
      write_reg(rfm_pkg::CSR_TEX_WIDTH, tw);
      write_reg(rfm_pkg::CSR_TEX_HEIGHT, th);
      csr_we <= 1'b0;
      cur_rows = rows;
      cur_cam_x = cx;
      cur_cam_y = cy;
      cur_tex_w = tw;
      cur_tex_h = th;
   endtask

   initial begin
      cast_word_type w;
      int next_reconfig;
      int choice;
      int eff_rows;
      int span;
      bit pressure_done;

      reset = 1'b1;
      req_valid = 1'b0;
      req_func = rfm_pkg::FUNC_SETUP;
      req_column = '0;
      req_start_row = '0;
      req_side = rfm_pkg::SIDE_X;
      req_dir_x_sign = rfm_pkg::DIR_ZERO;
      req_dir_y_sign = rfm_pkg::DIR_ZERO;
      req_map_x = '0;
      req_map_y = '0;
      req_wall_frac = '0;
      req_wall_dist = '0;
      csr_we = 1'b0;
      csr_index = rfm_pkg::CSR_SCREEN_ROWS;
      csr_wdata = '0;
      steady_flow = 1'b0;
      rsp_hold_cycles = 0;
      cur_rows = 480;
      cur_cam_x = 0;
      cur_cam_y = 0;
      cur_tex_w = 64;
      cur_tex_h = 64;
      words_sent = 0;
      next_reconfig = 0;
      pressure_done = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, first with the register values from reset.
      // A row word before any column is loaded must be ignored.
      send_word(row_word());

      // Positive x direction on an x side, with the map cell and offset at their maxima.
      // The last of the three rows is flagged, and the row word after it is ignored.
      w = setup_at(476, rfm_pkg::SIDE_X, rfm_pkg::DIR_POS, rfm_pkg::DIR_NEG, 24'h010000);
      w.column = '1;
      w.map_x = '1;
      w.map_y = '1;
      w.frac = '1;
      send_word(w);
      repeat (4) send_word(row_word());

      // Negative x direction with the map cell and offset at zero.
      w = setup_at(478, rfm_pkg::SIDE_X, rfm_pkg::DIR_NEG, rfm_pkg::DIR_POS, 24'h020000);
      w.column = '0;
      w.map_x = '0;
      w.map_y = '0;
      w.frac = '0;
      send_word(w);
      send_word(row_word());

      // An x side with zero x direction takes the point of a negative y side hit.
      send_word(setup_at(478, rfm_pkg::SIDE_X, rfm_pkg::DIR_ZERO, rfm_pkg::DIR_POS,
                         24'h018000));
      send_word(row_word());
      send_word(setup_at(478, rfm_pkg::SIDE_Y, rfm_pkg::DIR_ZERO, rfm_pkg::DIR_POS,
                         24'h030000));
      send_word(row_word());
      send_word(setup_at(478, rfm_pkg::SIDE_Y, rfm_pkg::DIR_RSVD, rfm_pkg::DIR_NEG,
                         24'hFFFFFF));
      send_word(row_word());
      // Direction code 3 counts as zero.
      send_word(setup_at(478, rfm_pkg::SIDE_Y, rfm_pkg::DIR_NEG, rfm_pkg::DIR_RSVD,
                         24'h00C000));
      send_word(row_word());

      // A zero wall distance saturates the weight.
      send_word(setup_at(478, rfm_pkg::SIDE_X, rfm_pkg::DIR_RSVD, rfm_pkg::DIR_ZERO, '0));
      send_word(row_word());

      // Rows above and at the horizon also saturate the weight.
      send_word(setup_at(238, rfm_pkg::SIDE_X, rfm_pkg::DIR_POS, rfm_pkg::DIR_POS,
                         24'h010000));
      send_word(row_word());
      send_word(row_word());

      // A short screen with the camera in a far corner makes the lerp go negative,
      // with a zero texture width and a texture height above the 10-bit range.
      write_regs(8, 22'h3FFFFF, 0, 0, 2047);
      send_word(setup_at(2, rfm_pkg::SIDE_Y, rfm_pkg::DIR_POS, rfm_pkg::DIR_POS,
                         24'h008000));
      send_word(row_word());
      send_word(row_word());

      // Lowering the height below the next row ends the column without a result.
      write_regs(4, cur_cam_x, cur_cam_y, cur_tex_w, cur_tex_h);
      send_word(row_word());
      send_word(row_word());

      // A zero height leaves any column inactive.
      write_regs(0, 0, 22'h3FFFFF, 1, 1025);
      send_word(setup_at(0, rfm_pkg::SIDE_X, rfm_pkg::DIR_POS, rfm_pkg::DIR_POS,
                         24'h010000));
      send_word(row_word());

      // A height above the row limit is clamped, so row 1023 is the last one.
      write_regs(2047, 22'h2AAAAA, 22'h155555, 1024, 3);
      send_word(setup_at(1022, rfm_pkg::SIDE_Y, rfm_pkg::DIR_NEG, rfm_pkg::DIR_NEG,
                         24'h001000));
      send_word(row_word());

      // Random part: mostly complete columns ending at the screen bottom, some columns cut
      // short by a new setup from anywhere on the screen, and some stray row words.
      while (words_sent < 650) begin
         if (words_sent >= next_reconfig) begin
            write_regs(pick_rows(), pick_cam(), pick_cam(), pick_tex(), pick_tex());
            steady_flow = ($urandom_range(3) == 0);
            next_reconfig = words_sent + 90;
         end
         if (!pressure_done && words_sent >= 300) begin
            // Hold the receiver off while a long column is offered, so that the unit
            // fills up and stops taking words.
            pressure_done = 1'b1;
            write_regs(480, cur_cam_x, cur_cam_y, cur_tex_w, cur_tex_h);
            rsp_hold_cycles = 700;
            send_column(466, 13);
         end
         eff_rows = (cur_rows > 1024) ? 1024 : cur_rows;
         choice = $urandom_range(99);
         if (choice < 80) begin
            span = ($urandom_range(19) == 0) ? $urandom_range(40, 8) : $urandom_range(6, 1);
            if (span > eff_rows - 1)
               span = eff_rows - 1;
            send_column(eff_rows - 1 - span, span);
            if ($urandom_range(4) == 0)
               send_word(row_word());
         end else if (choice < 92) begin
            send_column($urandom_range(1023), $urandom_range(3));
         end else begin
            send_word(row_word());
         end
      end

      drain();
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
